// File: rtl/swds_pkg.sv
// Shared types and constants of the sliding-window delay statistics block.
package swds_pkg;

  localparam int OUT_W         = 48;        // width of each reported delay field
  localparam int WIN_MS_W      = 16;        // width of the window register
  localparam int WIN_W         = 36;        // window in ns: 65535 * 1e6 < 2**36
  localparam int NS_PER_MS     = 1000000;
  localparam int WIN_MS_RESET  = 1000;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;

  // Register byte addresses
  localparam logic [APB_AW-1:0] ADDR_WINDOW_MS = 3'd0;

  // Input kinds carried on the slave-side tuser
  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;

  // Divider status toward the controller
  typedef struct packed {
    logic done;    // one-cycle pulse: quotient valid
    logic rem_nz;  // remainder is not zero
  } swds_div_stat_t;

endpackage

// File: rtl/swds_ring.sv
// Ring storage of arrival times and delays, one write and one registered read port.
module swds_ring
  import swds_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int TIME_BITS = 48
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [TIME_BITS-1:0]         wr_arrival,
  input  logic [TIME_BITS-1:0]         wr_delay,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [TIME_BITS-1:0]         rd_arrival,
  output logic [TIME_BITS-1:0]         rd_delay
);

  logic [TIME_BITS-1:0] arrival_mem [DEPTH];
  logic [TIME_BITS-1:0] delay_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      arrival_mem[wr_addr] <= wr_arrival;
      delay_mem[wr_addr]   <= wr_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_arrival <= arrival_mem[rd_addr];
      rd_delay   <= delay_mem[rd_addr];
    end
  end

endmodule

// File: rtl/swds_div.sv
// Restoring divider, one quotient bit per cycle.
module swds_div
  import swds_pkg::*;
#(
  parameter int NW = 59,
  parameter int DW = 11
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DW-1:0]  divisor,
  output logic [NW-1:0]  quotient,
  output swds_div_stat_t stat
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dsr;
  logic [CNTW-1:0] cnt;
  logic            busy;
  logic            done;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[NW-1]};
    diff     = trial - {1'b0, dsr};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient    = quo;
  assign stat.done   = done;
  assign stat.rem_nz = (rem != '0);

endmodule

// File: rtl/sliding_window_delay_stats.sv
// Top level of the sliding-window packet delay meter.
//
// Packet delay meter over a sliding time window. Each input word is either an
// arrival (tuser = 0) carrying the arrival time and the packet creation time,
// or a report request (tuser = 1) carrying the current time. Arrivals append
// the arrival time and the signed, saturated delay to a ring of DEPTH entries
// held in block RAM; a full ring drops its oldest entry and sets a sticky
// overflow flag. A report first retires every entry whose arrival time is at
// or before (now - window_ms * 1e6), oldest first, stopping at the first entry
// still inside the window, then returns min, max, truncated mean delay, the
// sample count and the overflow flag, and clears that flag. An empty window
// reports zero delays. An arrival is accepted and then written to the RAM. A
// report retires expired entries by reading and checking one RAM entry at a
// time, then the min/max/sum scan streams the RAM one entry per cycle, and
// the mean comes from a bit-serial divider. A finished result waits in the
// output register while the next word is taken. The RAM needs no clearing
// after reset.
module sliding_window_delay_stats
  import swds_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int TIME_BITS = 48
) (
  input  logic                                           clk,
  input  logic                                           rst,
  // slave side
  input  logic                                           s_tvalid,
  output logic                                           s_tready,
  // tdata, low bit up: time_now[TIME_BITS], creation_time[TIME_BITS], zero pad
  input  logic [((2*TIME_BITS+7)/8)*8-1:0]               s_tdata,
  // tuser: cmd (0 arrival, 1 report)
  input  logic                                           s_tuser,
  // master side
  output logic                                           m_tvalid,
  input  logic                                           m_tready,
  // tdata, low bit up: min delay[48], max delay[48], mean delay[48],
  // sample_count[clog2(DEPTH+1)], overflow[1], zero pad
  output logic [((3*48+$clog2(DEPTH+1)+1+7)/8)*8-1:0]    m_tdata,
  // configuration
  input  logic                                           psel,
  input  logic                                           penable,
  input  logic                                           pwrite,
  input  logic [APB_AW-1:0]                              paddr,
  input  logic [APB_DW-1:0]                              pwdata,
  output logic [APB_DW-1:0]                              prdata,
  output logic                                           pready
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int SUMW   = TIME_BITS + CW;
  localparam int PRODW  = TIME_BITS + CW + 1;
  localparam int CMPW   = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
  localparam int OUT_TDW = ((3*OUT_W + CW + 1 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_TDW - (3*OUT_W + CW + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ARRIVE   = 4'd1;
  localparam logic [3:0] S_DEADLINE = 4'd2;
  localparam logic [3:0] S_EXP_RD   = 4'd3;
  localparam logic [3:0] S_EXP_CHK  = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_DIV_GO   = 4'd7;
  localparam logic [3:0] S_DIV_WAIT = 4'd8;
  localparam logic [3:0] S_MEAN     = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [TIME_BITS-1:0] v);
    logic [63:0] w;
    w = 64'($signed(v));
    to_out = w[OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration: window register, and the window in ns kept alongside
  // ---------------------------------------------------------------------
  logic [WIN_MS_W-1:0] window_ms;
  logic [WIN_W-1:0]    win_ns;
  logic                cfg_wr;

  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WIN_MS_W'(WIN_MS_RESET);
      win_ns    <= WIN_W'(WIN_MS_RESET * NS_PER_MS);
    end else if (cfg_wr && (paddr[APB_AW-1:2] == ADDR_WINDOW_MS[APB_AW-1:2])) begin
      window_ms <= pwdata[WIN_MS_W-1:0];
      win_ns    <= WIN_W'(pwdata[WIN_MS_W-1:0]) * WIN_W'(NS_PER_MS);
    end
  end

  assign prdata = (paddr[APB_AW-1:2] == ADDR_WINDOW_MS[APB_AW-1:2]) ?
                  APB_DW'(window_ms) : '0;

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  logic [3:0]           state;
  logic [AW-1:0]        oldest_ptr;
  logic [CW-1:0]        entry_count;
  logic                 dropped_flag;

  // captured input word
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] cre;

  // report working registers
  logic [TIME_BITS-1:0] deadline;
  logic                 expire_ok;
  logic [AW-1:0]        rd_ptr;
  logic [CW-1:0]        issued;
  logic                 rd_pend;     // a scan read returns this cycle
  logic                 first;
  logic signed [TIME_BITS-1:0] mn;
  logic signed [TIME_BITS-1:0] mx;
  logic signed [SUMW-1:0]      sum;
  logic signed [PRODW-1:0]     prod;
  logic [TIME_BITS-1:0] mean;

  // output register
  logic                 out_valid;
  logic [OUT_TDW-1:0]   out_data;

  // ring ports
  logic                 ring_wr;
  logic [AW-1:0]        ring_waddr;
  logic [TIME_BITS-1:0] ring_wdelay;
  logic                 ring_rd;
  logic [AW-1:0]        ring_raddr;
  logic [TIME_BITS-1:0] rd_arrival;
  logic [TIME_BITS-1:0] rd_delay;

  // divider
  logic                 div_start;
  logic [SUMW-1:0]      div_num;
  logic [SUMW-1:0]      div_quo;
  swds_div_stat_t       div_stat;

  logic                 in_acc;
  logic                 ring_full;
  logic [AW:0]          tail_sum;
  logic [AW-1:0]        tail_idx;
  logic [TIME_BITS:0]   diff;
  logic                 scan_more;
  logic                 out_free;
  logic [TIME_BITS:0]   mean_wide;

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid & s_tready;
  assign out_free = ~out_valid | m_tready;

  // Tail slot for the next arrival; a full ring reuses the oldest slot.
  assign ring_full = (entry_count == CW'(DEPTH));
  always_comb begin
    tail_sum = (AW+1)'(oldest_ptr) + (AW+1)'(entry_count);
    if (tail_sum >= (AW+1)'(DEPTH)) begin
      tail_sum = tail_sum - (AW+1)'(DEPTH);
    end
    tail_idx = tail_sum[AW-1:0];
  end

  // Delay with saturation to the signed TIME_BITS range.
  always_comb begin
    diff = {1'b0, now} - {1'b0, cre};
    if (diff[TIME_BITS] != diff[TIME_BITS-1]) begin
      ring_wdelay = diff[TIME_BITS] ? {1'b1, {(TIME_BITS-1){1'b0}}} :
                                      {1'b0, {(TIME_BITS-1){1'b1}}};
    end else begin
      ring_wdelay = diff[TIME_BITS-1:0];
    end
  end

  assign ring_wr    = (state == S_ARRIVE);
  assign ring_waddr = ring_full ? oldest_ptr : tail_idx;

  assign scan_more  = (issued != entry_count);
  assign ring_rd    = (state == S_EXP_RD) || ((state == S_SCAN) && scan_more);
  assign ring_raddr = (state == S_SCAN) ? rd_ptr : oldest_ptr;

  assign div_start  = (state == S_DIV_GO);
  assign div_num    = SUMW'(sum - prod[SUMW-1:0]);

  // mean = min + floor(sum of (d - min) / n), moved toward zero when negative
  assign mean_wide  = {mn[TIME_BITS-1], mn} + {1'b0, div_quo[TIME_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      oldest_ptr   <= '0;
      entry_count  <= '0;
      dropped_flag <= 1'b0;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      // load a new result word, or drop the one just taken
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (s_tuser == CMD_REPORT) ? S_DEADLINE : S_ARRIVE;
          end
        end
        S_ARRIVE: begin
          // append; a full ring advances past the overwritten entry
          if (ring_full) begin
            oldest_ptr   <= ptr_inc(oldest_ptr);
            dropped_flag <= 1'b1;
          end else begin
            entry_count <= entry_count + 1'b1;
          end
          state <= S_IDLE;
        end
        S_DEADLINE: begin
          state <= S_EXP_RD;
        end
        S_EXP_RD: begin
          state <= (entry_count == '0) ? S_OUT : S_EXP_CHK;
        end
        S_EXP_CHK: begin
          if (expire_ok && (rd_arrival <= deadline)) begin
            oldest_ptr  <= ptr_inc(oldest_ptr);
            entry_count <= entry_count - 1'b1;
            state       <= S_EXP_RD;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= scan_more;
          if (!scan_more && !rd_pend) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            dropped_flag <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now <= s_tdata[TIME_BITS-1:0];
      cre <= s_tdata[2*TIME_BITS-1:TIME_BITS];
    end

    if (state == S_DEADLINE) begin
      expire_ok <= (CMPW'(now) >= CMPW'(win_ns));
      deadline  <= TIME_BITS'(CMPW'(now) - CMPW'(win_ns));
    end

    if (state == S_EXP_RD && entry_count == '0) begin
      mn   <= '0;
      mx   <= '0;
      mean <= '0;
    end

    if (state == S_EXP_CHK) begin
      rd_ptr <= oldest_ptr;
      issued <= '0;
      first  <= 1'b1;
      sum    <= '0;
    end

    if (state == S_SCAN) begin
      if (scan_more) begin
        rd_ptr <= ptr_inc(rd_ptr);
        issued <= issued + 1'b1;
      end
      if (rd_pend) begin
        first <= 1'b0;
        sum   <= sum + $signed({{CW{rd_delay[TIME_BITS-1]}}, rd_delay});
        if (first || ($signed(rd_delay) < mn)) begin
          mn <= $signed(rd_delay);
        end
        if (first || ($signed(rd_delay) > mx)) begin
          mx <= $signed(rd_delay);
        end
      end
    end

    if (state == S_MUL) begin
      prod <= $signed({1'b0, entry_count}) * mn;
    end

    if (state == S_MEAN) begin
      if (mean_wide[TIME_BITS] && div_stat.rem_nz) begin
        mean <= mean_wide[TIME_BITS-1:0] + 1'b1;
      end else begin
        mean <= mean_wide[TIME_BITS-1:0];
      end
    end

    if (state == S_OUT && out_free) begin
      out_data <= {{OUT_PAD{1'b0}}, dropped_flag, entry_count,
                   to_out(mean), to_out(mx), to_out(mn)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // ---------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------
  swds_ring #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ring (
    .clk        (clk),
    .wr_en      (ring_wr),
    .wr_addr    (ring_waddr),
    .wr_arrival (now),
    .wr_delay   (ring_wdelay),
    .rd_en      (ring_rd),
    .rd_addr    (ring_raddr),
    .rd_arrival (rd_arrival),
    .rd_delay   (rd_delay)
  );

  swds_div #(
    .NW (SUMW),
    .DW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (entry_count),
    .quotient (div_quo),
    .stat     (div_stat)
  );

endmodule
